FILE: design/mmc_pkg.sv
// Shared constants, codes and types of the magnetometer min/max calibrator.
package mmc_pkg;

  // Default raw sample width
  localparam int SAMPLE_W_DEF = 16;
  localparam int NUM_AXES     = 3;

  // Configuration and result widths
  localparam int CFG_W   = 16;
  localparam int OUT_W   = 24;
  localparam int SCALE_W = 24;
  localparam int FRAC_W  = 16;
  // Integer bits of the Q8.16 scale
  localparam int QSTEP_W = SCALE_W - FRAC_W;
  // Output is scale * (2m - offset_doubled) / 2^17
  localparam int OUT_SHIFT = FRAC_W + 1;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 24'h010000;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 24'hFFFFFF;

  localparam int OUT_MAX_I = 8388607;
  localparam int OUT_MIN_I = -8388608;

  // Register reset values
  localparam logic [CFG_W-1:0] SKIP_RST      = 16'd3;
  localparam logic [CFG_W-1:0] CALIB_END_RST = 16'd2500;
  // Running max start value for X and Z (Y starts at zero)
  localparam int AXIS_MAX_RST_XZ = -50;

  // Divider iterations, one quotient bit each
  localparam int DIV_STEPS  = SCALE_W;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  // Configuration register indexes
  typedef enum logic {
    REG_SKIP_COUNT = 1'b0,
    REG_CALIB_END  = 1'b1
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL_GLB,
    ST_CAL_CHK,
    ST_CAL_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

endpackage

FILE: design/mmc_div.sv
// Iterative restoring divider for the per-axis Q8.16 scale, one quotient bit per cycle.
module mmc_div #(
  parameter int SAMPLE_WIDTH = mmc_pkg::SAMPLE_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [SAMPLE_WIDTH:0]        span,
  input  logic [SAMPLE_WIDTH:0]        range,
  output logic                         done,
  output logic [mmc_pkg::SCALE_W-1:0]  quo
);
  import mmc_pkg::*;

  localparam int RNG_W = SAMPLE_WIDTH + 1;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [RNG_W-1:0]      rem_r;
  logic [RNG_W-1:0]      den_r;
  logic [SCALE_W-1:0]    lo_r;
  logic [SCALE_W-1:0]    quo_r;
  logic [RNG_W:0]        trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_r, lo_r[SCALE_W-1]} - {1'b0, den_r};

  // Control: busy flag, step counter, completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= DIV_STEP_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // Datapath: numerator is span * 2^16, its top part starts the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= range;
      rem_r <= RNG_W'(span >> QSTEP_W);
      lo_r  <= {span[QSTEP_W-1:0], FRAC_W'(0)};
      quo_r <= '0;
    end else if (busy_r) begin
      lo_r <= {lo_r[SCALE_W-2:0], 1'b0};
      if (!trial[RNG_W]) begin
        rem_r <= trial[RNG_W-1:0];
        quo_r <= {quo_r[SCALE_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[RNG_W-2:0], lo_r[SCALE_W-1]};
        quo_r <= {quo_r[SCALE_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: design/magnetometer_minmax_calibrator.sv
// Top level of the magnetometer min/max (hard- and soft-iron) calibrator.
//
// Input channel (in_valid/in_ready): one signed three-axis sample per
// transaction. Result channel (out_valid/out_ready): one corrected sample
// per input, saturated to 24 bits, with a flag that calibration has run.
// Configuration: cfg_we/cfg_index/cfg_data write skip_count and calib_end,
// taken at once; write them only while no sample is in flight.
//
// Timing: a normal sample goes from the accepting edge through a multiply and
// a round/saturate step per axis on a single shared multiplier, then the output
// register load. The sample that triggers calibration adds an offset/span step
// plus, per axis, one check step and, where the divider is started, a wait on
// the bit-serial divider. The block takes one sample at a time; in_ready is
// low while it works.
//
// Reset (rst_n, synchronous): registers to their defaults, count and offsets
// cleared, extremes to their start values, scales to 1.0, no result pending.
// A stalled receiver holds the result in the output register; the block
// still accepts the next sample and works on it, then waits to hand it over.
module magnetometer_minmax_calibrator #(
  parameter int SAMPLE_WIDTH = mmc_pkg::SAMPLE_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              cfg_we,
  input  mmc_pkg::reg_idx_t                 cfg_index,
  input  logic [mmc_pkg::CFG_W-1:0]         cfg_data,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_mag_x,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_mag_y,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_mag_z,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mmc_pkg::OUT_W-1:0]  out_x,
  output logic signed [mmc_pkg::OUT_W-1:0]  out_y,
  output logic signed [mmc_pkg::OUT_W-1:0]  out_z,
  output logic                              out_calibrated
);
  import mmc_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int RNG_W  = SW + 1;
  localparam int DIFF_W = SW + 2;
  localparam int PROD_W = DIFF_W + SCALE_W + 1;
  localparam int CMP_W  = RNG_W + QSTEP_W;

  localparam logic signed [PROD_W-1:0] RND_ADD = PROD_W'((1 << OUT_SHIFT) - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI  = PROD_W'(OUT_MAX_I);
  localparam logic signed [PROD_W-1:0] SAT_LO  = PROD_W'(OUT_MIN_I);

  // Sequencer
  state_t state_r, state_nxt;
  logic [1:0] ax_r;

  // Configuration registers
  logic [CFG_W-1:0] skip_r;
  logic [CFG_W-1:0] end_r;

  // Calibration state
  logic [CFG_W-1:0]        cnt_r;
  logic                    done_r;
  logic signed [SW-1:0]    max_r [NUM_AXES];
  logic signed [SW-1:0]    min_r [NUM_AXES];
  logic signed [RNG_W-1:0] od_r  [NUM_AXES];
  logic [SCALE_W-1:0]      scale_r [NUM_AXES];
  logic [RNG_W-1:0]        span_r;

  // Working sample and results
  logic signed [SW-1:0]     smp_r [NUM_AXES];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [OUT_W-1:0]  res_r [NUM_AXES];

  // Output register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_x_r;
  logic signed [OUT_W-1:0] out_y_r;
  logic signed [OUT_W-1:0] out_z_r;
  logic                    out_cal_r;

  // Control strobes
  logic in_acc;
  logic div_start;
  logic out_load;
  logic ax_last;

  // Datapath signals
  logic signed [SW-1:0]     in_mag [NUM_AXES];
  logic signed [SW-1:0]     gmax_c;
  logic signed [SW-1:0]     gmin_c;
  logic signed [RNG_W-1:0]  range_c;
  logic                     range_pos;
  logic                     scale_sat;
  logic signed [DIFF_W-1:0] diff_c;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] shr_c;
  logic signed [OUT_W-1:0]  sat_c;
  logic                     div_done;
  logic [SCALE_W-1:0]       div_quo;

  assign in_mag[0] = in_mag_x;
  assign in_mag[1] = in_mag_y;
  assign in_mag[2] = in_mag_z;

  // Global extremes over the three axes
  always_comb begin
    gmax_c = max_r[0];
    gmin_c = min_r[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (max_r[a] > gmax_c) gmax_c = max_r[a];
      if (min_r[a] < gmin_c) gmin_c = min_r[a];
    end
  end

  // Axis range and scale saturation check (scale >= 2^24 iff span >= range * 2^8)
  assign range_c   = RNG_W'(max_r[ax_r]) - RNG_W'(min_r[ax_r]);
  assign range_pos = !range_c[RNG_W-1] && (range_c != '0);
  assign scale_sat = CMP_W'(span_r) >= {range_c, QSTEP_W'(0)};

  // Shared multiplier: scale * (2m - offset_doubled)
  assign diff_c = (DIFF_W'(smp_r[ax_r]) <<< 1) - DIFF_W'(od_r[ax_r]);
  assign prod_c = PROD_W'(diff_c) * PROD_W'(signed'({1'b0, scale_r[ax_r]}));

  // Truncate toward zero, then saturate to 24 bits
  assign shr_c = (prod_r + (prod_r[PROD_W-1] ? RND_ADD : PROD_W'(0))) >>> OUT_SHIFT;
  assign sat_c = (shr_c > SAT_HI) ? OUT_W'(OUT_MAX_I) :
                 (shr_c < SAT_LO) ? OUT_W'(OUT_MIN_I) : shr_c[OUT_W-1:0];

  // Scale divider
  mmc_div #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .span  (span_r),
    .range (range_c),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Control outputs of the sequencer
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    in_acc    = in_ready && in_valid;
    div_start = (state_r == ST_CAL_CHK) && range_pos && !scale_sat;
    out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
    ax_last   = (ax_r == 2'd2);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!done_r && (cnt_r >= skip_r) && (cnt_r >= end_r)) begin
            state_nxt = ST_CAL_GLB;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_CAL_GLB: state_nxt = ST_CAL_CHK;
      ST_CAL_CHK: begin
        if (div_start) begin
          state_nxt = ST_CAL_DIV;
        end else if (ax_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_CAL_DIV: begin
        if (div_done) begin
          state_nxt = ax_last ? ST_MUL : ST_CAL_CHK;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = ax_last ? ST_OUT : ST_MUL;
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer state and axis counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE:    ax_r <= '0;
        ST_CAL_GLB: ax_r <= '0;
        ST_CAL_CHK: if (!div_start) ax_r <= ax_last ? 2'd0 : ax_r + 1'b1;
        ST_CAL_DIV: if (div_done) ax_r <= ax_last ? 2'd0 : ax_r + 1'b1;
        ST_ACC:     if (!ax_last) ax_r <= ax_r + 1'b1;
        default:    ax_r <= ax_r;
      endcase
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RST;
      end_r  <= CALIB_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKIP_COUNT: skip_r <= cfg_data;
        REG_CALIB_END:  end_r  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Statistics, offsets and scales
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      span_r <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        max_r[a]   <= (a == 1) ? '0 : SW'(AXIS_MAX_RST_XZ);
        min_r[a]   <= '0;
        od_r[a]    <= '0;
        scale_r[a] <= SCALE_ONE;
      end
    end else begin
      // Count and track extremes on acceptance
      if (in_acc && !done_r) begin
        if (cnt_r < skip_r) begin
          cnt_r <= cnt_r + 1'b1;
        end else if (cnt_r < end_r) begin
          cnt_r <= cnt_r + 1'b1;
          for (int a = 0; a < NUM_AXES; a++) begin
            if (in_mag[a] > max_r[a]) max_r[a] <= in_mag[a];
            if (in_mag[a] < min_r[a]) min_r[a] <= in_mag[a];
          end
        end
      end
      // Offsets and global span
      if (state_r == ST_CAL_GLB) begin
        done_r <= 1'b1;
        span_r <= RNG_W'(gmax_c) - RNG_W'(gmin_c);
        for (int a = 0; a < NUM_AXES; a++) begin
          od_r[a] <= RNG_W'(max_r[a]) + RNG_W'(min_r[a]);
        end
      end
      // Per-axis scale
      if (state_r == ST_CAL_CHK && !div_start) begin
        scale_r[ax_r] <= range_pos ? SCALE_MAX : SCALE_ONE;
      end
      if (state_r == ST_CAL_DIV && div_done) begin
        scale_r[ax_r] <= div_quo;
      end
    end
  end

  // Sample capture, product and per-axis results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        smp_r[a] <= in_mag[a];
      end
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_c;
    end
    if (state_r == ST_ACC) begin
      res_r[ax_r] <= sat_c;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r   <= res_r[0];
      out_y_r   <= res_r[1];
      out_z_r   <= res_r[2];
      out_cal_r <= done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_z          = out_z_r;
  assign out_calibrated = out_cal_r;

  // Calibration is final until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("calibration flag dropped");

  // Divider completes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_CAL_DIV))
    else $error("divider done outside of divide wait");

  // Axis range never exceeds the global span, so scales are at least 1.0
  a_scale_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (scale_r[ax_r] >= SCALE_ONE))
    else $error("scale below 1.0");

  // No new result is loaded into the output register while it still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !$past(out_load) || (state_r == ST_IDLE))
    else $error("result register overwritten");

endmodule
